// ----- design/rpcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpcc_pkg
// shared beat types and constants for the range preserving coefficient cipher
// ----------------------------------------------------------------------------
package rpcc_pkg;

    localparam int unsigned COEF_W = 16;
    localparam int unsigned POS_W  = 5;   // holds a bit count from 0 to COEF_W

    typedef logic [COEF_W-1:0] word_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic        [COEF_W-1:0] keystream_word;
        logic signed [COEF_W-1:0] block_min;
        logic signed [COEF_W-1:0] block_max;
        logic                     last_in_block;
    } item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient_out;
        logic                     last_out;
    } result_t;

    // bit length of a word: index of the highest set bit plus one
    function automatic pos_t bit_len(input word_t v);
        pos_t n;
        n = '0;
        for (int i = 0; i < COEF_W; i++)
        begin
            if (v[i])
            begin
                n = pos_t'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ----- design/rpcc_xform.sv -----
// ----------------------------------------------------------------------------
// rpcc_xform
// combinational cipher step: keystream xor on the varying low bits, then
// sign extension from the block's sign position
// ----------------------------------------------------------------------------
module rpcc_xform
(
    input  rpcc_pkg::item_t   item,
    input  logic              nonzero_only,
    output rpcc_pkg::result_t result
);

    rpcc_pkg::word_t coef;
    rpcc_pkg::word_t mag_min;
    rpcc_pkg::word_t mag_max;
    rpcc_pkg::pos_t  pos_min;
    rpcc_pkg::pos_t  pos_max;
    rpcc_pkg::pos_t  spos;
    rpcc_pkg::pos_t  nbits;
    rpcc_pkg::word_t key_mask;
    rpcc_pkg::word_t hi_mask;
    rpcc_pkg::word_t mixed;
    rpcc_pkg::word_t ct;
    logic            uniform;
    logic            skip;

    always_comb
    begin
        coef    = rpcc_pkg::word_t'(item.coefficient);
        // redundant sign bits: measure the magnitude of x or of ~x
        mag_min = item.block_min[rpcc_pkg::COEF_W-1] ? ~item.block_min : item.block_min;
        mag_max = item.block_max[rpcc_pkg::COEF_W-1] ? ~item.block_max : item.block_max;
        pos_min = rpcc_pkg::bit_len(mag_min);
        pos_max = rpcc_pkg::bit_len(mag_max);
        spos    = (pos_min > pos_max) ? pos_min : pos_max;

        if (item.block_min[rpcc_pkg::COEF_W-1] == item.block_max[rpcc_pkg::COEF_W-1])
        begin
            nbits = rpcc_pkg::bit_len(item.block_min ^ item.block_max);
        end
        else
        begin
            nbits = spos + rpcc_pkg::pos_t'(1);
        end

        // a shift by the full width clears the word, so a count of 16 keys all bits
        key_mask = ~({rpcc_pkg::COEF_W{1'b1}} << nbits);
        hi_mask  = {rpcc_pkg::COEF_W{1'b1}} << spos;
        mixed    = coef ^ (item.keystream_word & key_mask);
        ct       = (mixed & ~hi_mask)
                 | (mixed[spos[rpcc_pkg::POS_W-2:0]] ? hi_mask : '0);

        uniform  = (item.block_min == item.block_max);
        skip     = uniform || (nonzero_only && ((coef == '0) || (ct == '0)));

        result.coefficient_out = skip ? item.coefficient : $signed(ct);
        result.last_out        = item.last_in_block;
    end

endmodule

// ----- design/range_preserving_coeff_cipher.sv -----
// ----------------------------------------------------------------------------
// range_preserving_coeff_cipher
// keystream cipher on a coefficient's varying low bits, keeping the block range
// ----------------------------------------------------------------------------
// usage
//   item channel   : item_valid / item_stall, one coefficient beat with its
//                    block min and max, keystream word and end-of-block mark
//   result channel : result_valid / result_stall, transformed coefficient and
//                    copied end-of-block mark, one result beat per item beat
//   cfg channel    : cfg_valid / cfg_ready, writes nonzero_only; ready is
//                    always high, write only while the block is idle
//   path           : the item beat is taken into the input register, passes
//                    the cipher step and leaves from the result register
//   throughput     : one beat per cycle sustained while result_stall is low;
//                    the whole cipher step is one pass of combinational logic
//                    between the two registers
//   stall          : a stalled result holds; the input register keeps taking
//                    beats until both registers are full, then item_stall rises
//   reset          : rst_n clears both pipeline valids and nonzero_only
// ----------------------------------------------------------------------------
module range_preserving_coeff_cipher
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              item_valid,
    output logic              item_stall,
    input  rpcc_pkg::item_t   item,

    output logic              result_valid,
    input  logic              result_stall,
    output rpcc_pkg::result_t result,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    logic              nonzero_only_reg;
    logic              in_valid_reg;
    rpcc_pkg::item_t   in_beat_reg;
    logic              out_valid_reg;
    rpcc_pkg::result_t out_beat_reg;
    rpcc_pkg::result_t out_beat_next;
    logic              out_load;
    logic              in_load;

    // result register frees up when empty or when its beat is taken
    assign out_load   = !out_valid_reg || !result_stall;
    // input register takes a beat when empty or when it is draining
    assign in_load    = !in_valid_reg || out_load;
    assign item_stall = !in_load;
    assign cfg_ready  = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonzero_only_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            nonzero_only_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && item_valid)
        begin
            in_beat_reg <= item;
        end
    end

    // single pass cipher step
    rpcc_xform u_xform
    (
        .item         (in_beat_reg),
        .nonzero_only (nonzero_only_reg),
        .result       (out_beat_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_beat_reg;

endmodule

// ----- design/rpcc_checker.sv -----
// ----------------------------------------------------------------------------
// rpcc_checker
// port level checks for the range preserving coefficient cipher
// ----------------------------------------------------------------------------
module rpcc_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  logic              result_valid,
    input  logic              result_stall,
    input  rpcc_pkg::result_t result
);

    logic item_acc;

    assign item_acc = item_valid && !item_stall;

    // stalled result beat stays
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result beat changed");

    // empty output register never blocks the item side
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item stalled with empty result register");

    // idle, unstalled cycles with no item beat drain both pipeline registers
    assert property (@(posedge clk) disable iff (!rst_n)
        (!item_acc && !result_stall) ##1 (!item_acc && !result_stall) |=> !result_valid)
        else $error("result beat appeared without an item beat");

endmodule

bind range_preserving_coeff_cipher rpcc_checker u_rpcc_checker (.*);
